FILE: rtl/amgt_pkg.sv
// Shared types and constants for the adjacency-matrix traversal engine.
// No dependencies; compiled first.
package amgt_pkg;

    localparam int VERTEX_W   = 4;
    localparam int ROW_BITS_W = 16;
    localparam int INDEX_W    = 4;
    localparam int COUNT_W    = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WALK_MODE    = 1'b1;

    localparam logic [COUNT_W-1:0] VERTEX_COUNT_RST = 5'd16;

    // item command codes
    localparam logic CMD_LOAD_ROW = 1'b0;
    localparam logic CMD_START    = 1'b1;

    // walk modes
    localparam logic WALK_BFS = 1'b0;
    localparam logic WALK_DFS = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_POP,
        ST_DONE,
        ST_BAD
    } state_t;

    typedef struct packed {
        logic                  cmd;
        logic [INDEX_W-1:0]    row_index;
        logic [ROW_BITS_W-1:0] row_bits;
        logic [INDEX_W-1:0]    start_vertex;
    } item_t;

    // controller -> datapath
    typedef struct packed {
        logic load_row;
        logic start_init;
        logic take;
        logic pop;
        logic fetch_row;
        logic emit_last;
        logic emit_bad;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic item_start;
        logic start_bad;
        logic cand_found;
        logic list_empty;
        logic slot_free;
    } dp_status_t;

endpackage

FILE: rtl/amgt_in_if.sv
// Input channel of the traversal engine: valid/ready plus item payload.
// Depends on amgt_pkg.
interface amgt_in_if;
    import amgt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic [INDEX_W-1:0]    row_index;
    logic [ROW_BITS_W-1:0] row_bits;
    logic [INDEX_W-1:0]    start_vertex;

    modport source (output valid, cmd, row_index, row_bits, start_vertex, input ready);
    modport sink   (input valid, cmd, row_index, row_bits, start_vertex, output ready);
endinterface

FILE: rtl/amgt_out_if.sv
// Result channel of the traversal engine: valid/ready plus one visited vertex.
// Depends on amgt_pkg.
interface amgt_out_if;
    import amgt_pkg::*;

    logic                valid;
    logic                ready;
    logic [VERTEX_W-1:0] vertex;
    logic                last;
    logic                all_reached;
    logic                bad_start;

    modport source (output valid, vertex, last, all_reached, bad_start, input ready);
    modport sink   (input valid, vertex, last, all_reached, bad_start, output ready);
endinterface

FILE: rtl/amgt_ctrl.sv
// Traversal controller: sequences loads, scans, list pops and final results.
// Depends on amgt_pkg; drives the datapath through dp_cmd_t.
module amgt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  amgt_pkg::dp_status_t status,
    output amgt_pkg::dp_cmd_t    cmd
);
    import amgt_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && status.item_start)
                begin
                    state_next = status.start_bad ? ST_BAD : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!status.cand_found)
                begin
                    state_next = status.list_empty ? ST_DONE : ST_POP;
                end
            end
            ST_POP:
            begin
                state_next = ST_SCAN;
            end
            ST_DONE, ST_BAD:
            begin
                if (status.slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_ready = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready     = 1'b1;
                cmd.load_row   = accept && !status.item_start;
                cmd.start_init = accept && status.item_start && !status.start_bad;
            end
            ST_SCAN:
            begin
                // a found vertex pushes the held one out, so it needs a free slot
                cmd.take = status.cand_found && status.slot_free;
                cmd.pop  = !status.cand_found && !status.list_empty;
            end
            ST_POP:
            begin
                cmd.fetch_row = 1'b1;
            end
            ST_DONE:
            begin
                cmd.emit_last = status.slot_free;
            end
            ST_BAD:
            begin
                cmd.emit_bad = status.slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && !status.cand_found && status.list_empty)
        |=> (state_reg == ST_DONE))
        else $error("scan with empty list did not finish");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_row, cmd.start_init, cmd.take, cmd.pop,
                  cmd.fetch_row, cmd.emit_last, cmd.emit_bad}))
        else $error("more than one datapath command");

    a_pop_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |=> cmd.fetch_row)
        else $error("list pop not followed by row fetch");
`endif

endmodule

FILE: rtl/amgt_datapath.sv
// Traversal datapath: row memory, work list, visited marks, lowest-unvisited
// encoder, held vertex and result register. Depends on amgt_pkg.
module amgt_datapath #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [amgt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [amgt_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  amgt_pkg::item_t                     item,
    input  amgt_pkg::dp_cmd_t                   cmd,
    output amgt_pkg::dp_status_t                status,
    output logic                                res_valid,
    input  logic                                res_ready,
    output logic [amgt_pkg::VERTEX_W-1:0]       res_vertex,
    output logic                                res_last,
    output logic                                res_all_reached,
    output logic                                res_bad_start
);
    import amgt_pkg::*;

    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);

    // storage
    logic [MAX_VERTICES-1:0] rows_mem [MAX_VERTICES];
    logic [VW-1:0]           work_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] row_rd_reg;
    logic [VW-1:0]           work_rd_reg;

    logic [COUNT_W-1:0]      vertex_count_reg;
    logic                    walk_mode_reg;
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [CW-1:0]           head_reg;
    logic [CW-1:0]           tail_reg;
    logic [CW-1:0]           k_reg;
    logic [VW-1:0]           pend_reg;

    logic                    out_valid_reg;
    logic [VERTEX_W-1:0]     out_vertex_reg;
    logic                    out_last_reg;
    logic                    out_all_reg;
    logic                    out_bad_reg;

    logic [CW-1:0]           n_cnt;
    logic [MAX_VERTICES-1:0] nmask;
    logic [MAX_VERTICES-1:0] cand;
    logic [VW-1:0]           take_idx;
    logic [VW-1:0]           s_idx;
    logic [CW-1:0]           tail_m2;
    logic                    row_re;
    logic [VW-1:0]           row_raddr;
    logic                    row_we;
    logic                    work_we;
    logic [VW-1:0]           work_waddr;
    logic [VW-1:0]           work_wdata;
    logic [VW-1:0]           work_raddr;
    logic                    slot_free;

    assign n_cnt = (32'(vertex_count_reg) > 32'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                              : CW'(vertex_count_reg);
    assign s_idx   = VW'(item.start_vertex);
    assign tail_m2 = tail_reg - CW'(2);

    always_comb
    begin
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            nmask[i] = (i < int'(n_cnt));
        end
    end

    assign cand = row_rd_reg & ~visited_reg & nmask;

    // lowest set bit of the candidate set
    always_comb
    begin
        take_idx = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                take_idx = VW'(i);
            end
        end
    end

    assign slot_free = !out_valid_reg || res_ready;

    assign status.item_start = (item.cmd == CMD_START);
    assign status.start_bad  = (32'(item.start_vertex) >= 32'(n_cnt));
    assign status.cand_found = |cand;
    assign status.list_empty = (walk_mode_reg == WALK_DFS) ? (tail_reg == CW'(1))
                                                           : (head_reg == tail_reg);
    assign status.slot_free  = slot_free;

    // memory port control
    assign row_we = cmd.load_row && (32'(item.row_index) < 32'(MAX_VERTICES));
    assign row_re = cmd.start_init || cmd.fetch_row
                 || (cmd.take && walk_mode_reg == WALK_DFS);

    always_comb
    begin
        row_raddr = take_idx;
        if (cmd.start_init)
        begin
            row_raddr = s_idx;
        end
        else if (cmd.fetch_row)
        begin
            row_raddr = work_rd_reg;
        end
    end

    assign work_we    = cmd.start_init || cmd.take;
    assign work_waddr = cmd.start_init ? '0 : tail_reg[VW-1:0];
    assign work_wdata = cmd.start_init ? s_idx : take_idx;
    assign work_raddr = (walk_mode_reg == WALK_DFS) ? tail_m2[VW-1:0] : head_reg[VW-1:0];

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            rows_mem[VW'(item.row_index)] <= MAX_VERTICES'(item.row_bits);
        end
        if (row_re)
        begin
            row_rd_reg <= rows_mem[row_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (work_we)
        begin
            work_mem[work_waddr] <= work_wdata;
        end
        if (cmd.pop)
        begin
            work_rd_reg <= work_mem[work_raddr];
        end
    end

    // configuration and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VERTEX_COUNT_RST;
            walk_mode_reg    <= WALK_BFS;
            visited_reg      <= '0;
            head_reg         <= '0;
            tail_reg         <= '0;
            k_reg            <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_VERTEX_COUNT: vertex_count_reg <= cfg_data;
                    CFG_WALK_MODE:    walk_mode_reg    <= cfg_data[0];
                    default:          ;
                endcase
            end

            if (cmd.start_init)
            begin
                visited_reg <= MAX_VERTICES'(1) << s_idx;
                head_reg    <= CW'(1);
                tail_reg    <= CW'(1);
                k_reg       <= CW'(1);
            end
            else if (cmd.take)
            begin
                visited_reg <= visited_reg | (MAX_VERTICES'(1) << take_idx);
                tail_reg    <= tail_reg + CW'(1);
                k_reg       <= k_reg + CW'(1);
            end
            else if (cmd.pop)
            begin
                if (walk_mode_reg == WALK_DFS)
                begin
                    tail_reg <= tail_reg - CW'(1);
                end
                else
                begin
                    head_reg <= head_reg + CW'(1);
                end
            end

            if (cmd.take || cmd.emit_last || cmd.emit_bad)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // held vertex and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.start_init)
        begin
            pend_reg <= s_idx;
        end
        else if (cmd.take)
        begin
            pend_reg <= take_idx;
        end

        if (cmd.take)
        begin
            out_vertex_reg <= VERTEX_W'(pend_reg);
            out_last_reg   <= 1'b0;
            out_all_reg    <= 1'b0;
            out_bad_reg    <= 1'b0;
        end
        else if (cmd.emit_last)
        begin
            out_vertex_reg <= VERTEX_W'(pend_reg);
            out_last_reg   <= 1'b1;
            out_all_reg    <= (k_reg == n_cnt);
            out_bad_reg    <= 1'b0;
        end
        else if (cmd.emit_bad)
        begin
            out_vertex_reg <= '0;
            out_last_reg   <= 1'b1;
            out_all_reg    <= 1'b0;
            out_bad_reg    <= 1'b1;
        end
    end

    assign res_valid       = out_valid_reg;
    assign res_vertex      = out_vertex_reg;
    assign res_last        = out_last_reg;
    assign res_all_reached = out_all_reg;
    assign res_bad_start   = out_bad_reg;

`ifndef SYNTHESIS
    a_mark_one: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |=> ($countones(visited_reg) == $countones($past(visited_reg)) + 1))
        else $error("take did not add exactly one visited vertex");

    a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(tail_reg) <= 32'(MAX_VERTICES)) && (32'(head_reg) <= 32'(MAX_VERTICES)))
        else $error("work list pointer beyond capacity");

    a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_bad_reg) |-> (out_last_reg && !out_all_reg
                                            && out_vertex_reg == '0))
        else $error("bad start result malformed");
`endif

endmodule

FILE: rtl/adjacency_matrix_graph_traversal.sv
// Channel   Dir  Handshake      Payload
// item      in   valid/ready    cmd, row_index, row_bits, start_vertex
// result    out  valid/ready    vertex, last, all_reached, bad_start
// cfg       in   cfg_we only    cfg_index, cfg_data
//
// A row load is written into the row memory when it is accepted. A traversal runs from
// acceptance to the next item through these steps: the accept, one take per unvisited
// neighbor found in the scan, an empty scan plus a row fetch per list pop (each dequeued
// vertex breadth-first, each backtrack depth-first), the scan that ends the walk and the
// final result; row fetches go through the single registered read port of the row memory.
// A bad start registers its result in the bad state once the result slot is free. Reset
// clears control state only; rows are undefined until loaded. A stalled result holds the
// scan; the next item is taken while the final result still waits.
module adjacency_matrix_graph_traversal #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [amgt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [amgt_pkg::CFG_DATA_W-1:0] cfg_data,
    amgt_in_if.sink                         item,
    amgt_out_if.source                      result
);
    import amgt_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    item_t      item_data;

    assign item_data.cmd          = item.cmd;
    assign item_data.row_index    = item.row_index;
    assign item_data.row_bits     = item.row_bits;
    assign item_data.start_vertex = item.start_vertex;

    amgt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .status     (status),
        .cmd        (cmd)
    );

    amgt_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .item            (item_data),
        .cmd             (cmd),
        .status          (status),
        .res_valid       (result.valid),
        .res_ready       (result.ready),
        .res_vertex      (result.vertex),
        .res_last        (result.last),
        .res_all_reached (result.all_reached),
        .res_bad_start   (result.bad_start)
    );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for adjacency_matrix_graph_traversal: row loads, BFS/DFS walks,
// bad starts and count limits, checked against an in-bench visit-order predictor.
// Depends on amgt_pkg, amgt_in_if, amgt_out_if and the RTL top level.
module tb;
    import amgt_pkg::*;

    localparam int MAX_V         = 16;
    localparam int SETTLE_CYCLES = 3 * MAX_V + 12;
    localparam int LONG_HOLD     = 400;
    localparam int RANDOM_PHASES = 14;
    localparam int PHASE_ITEMS   = 30;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex;
        logic                last;
        logic                all_reached;
        logic                bad_start;
    } visit_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    amgt_in_if  item_ch ();
    amgt_out_if result_ch ();

    adjacency_matrix_graph_traversal #(.MAX_VERTICES(MAX_V)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    // predictor state
    logic [ROW_BITS_W-1:0] adj_rows [MAX_V];
    logic [COUNT_W-1:0]    cfg_count = VERTEX_COUNT_RST;
    logic                  cfg_mode  = WALK_BFS;
    visit_t                visit_q [$];

    int mismatch_count  = 0;
    int burst_left      = 0;
    int hold_requests   = 0;
    int hold_served     = 0;
    int hold_off_cycles = 0;
    int pattern_age     = 0;
    logic [7:0] stall_pattern = 8'hFF;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < 200)
            $display("MISMATCH @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic int active_vertices();
        return (cfg_count > MAX_V) ? MAX_V : int'(cfg_count);
    endfunction

    // Expected visit order for one accepted transaction.
    task automatic predict_item(input item_t it);
        logic [MAX_V-1:0] seen;
        int order [$];
        int work [$];
        int n;
        int v;
        bit found;
        visit_t vis;
        if (it.cmd == CMD_LOAD_ROW)
        begin
            adj_rows[it.row_index] = it.row_bits;
            return;
        end
        n = active_vertices();
        if (it.start_vertex >= n)
        begin
            vis = '{vertex: '0, last: 1'b1, all_reached: 1'b0, bad_start: 1'b1};
            visit_q.push_back(vis);
            return;
        end
        seen = '0;
        seen[it.start_vertex] = 1'b1;
        order.push_back(int'(it.start_vertex));
        work.push_back(int'(it.start_vertex));
        while (work.size() != 0)
        begin
            if (cfg_mode == WALK_BFS)
            begin
                v = work.pop_front();
                for (int i = 0; i < n; i++)
                    if (adj_rows[v][i] && !seen[i])
                    begin
                        seen[i] = 1'b1;
                        work.push_back(i);
                        order.push_back(i);
                    end
            end
            else
            begin
                // preorder: descend into lowest unvisited neighbor of stack top
                v = work[$];
                found = 1'b0;
                for (int i = 0; i < n && !found; i++)
                    if (adj_rows[v][i] && !seen[i])
                    begin
                        found = 1'b1;
                        seen[i] = 1'b1;
                        work.push_back(i);
                        order.push_back(i);
                    end
                if (!found)
                    void'(work.pop_back());
            end
        end
        foreach (order[k])
        begin
            vis.vertex      = VERTEX_W'(order[k]);
            vis.last        = (k == order.size() - 1);
            vis.all_reached = vis.last && (order.size() == n);
            vis.bad_start   = 1'b0;
            visit_q.push_back(vis);
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        visit_t exp_v;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (visit_q.size() == 0)
                report_mismatch($sformatf("unexpected result vertex %0d", result_ch.vertex));
            else
            begin
                exp_v = visit_q.pop_front();
                if (result_ch.vertex !== exp_v.vertex)
                    report_mismatch($sformatf("vertex %0d, expected %0d",
                                              result_ch.vertex, exp_v.vertex));
                if (result_ch.last !== exp_v.last)
                    report_mismatch($sformatf("last %b, expected %b",
                                              result_ch.last, exp_v.last));
                if (result_ch.all_reached !== exp_v.all_reached)
                    report_mismatch($sformatf("all_reached %b, expected %b",
                                              result_ch.all_reached, exp_v.all_reached));
                if (result_ch.bad_start !== exp_v.bad_start)
                    report_mismatch($sformatf("bad_start %b, expected %b",
                                              result_ch.bad_start, exp_v.bad_start));
            end
        end
    end

    // Result ready: rotating stall pattern, reloaded now and then; long hold-off on request
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served     = hold_requests;
            hold_off_cycles = LONG_HOLD;
        end
        if (hold_off_cycles > 0)
        begin
            result_ch.ready <= 1'b0;
            hold_off_cycles--;
        end
        else
        begin
            if (pattern_age == 0)
            begin
                pattern_age   = $urandom_range(16, 96);
                stall_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
            end
            pattern_age--;
            result_ch.ready <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
        end
    end

    // Sends one transaction; valid stays high across a burst.
    task automatic send_item(input item_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_ch.valid        <= 1'b1;
        item_ch.cmd          <= it.cmd;
        item_ch.row_index    <= it.row_index;
        item_ch.row_bits     <= it.row_bits;
        item_ch.start_vertex <= it.start_vertex;
        do
            @(posedge clk);
        while (!item_ch.ready);
        predict_item(it);
    endtask

    function automatic item_t load_item(input int row, input logic [ROW_BITS_W-1:0] bits);
        item_t it;
        it.cmd          = CMD_LOAD_ROW;
        it.row_index    = INDEX_W'(row);
        it.row_bits     = bits;
        it.start_vertex = INDEX_W'($urandom_range(0, MAX_V - 1));
        return it;
    endfunction

    function automatic item_t start_item(input int v);
        item_t it;
        it.cmd          = CMD_START;
        it.row_index    = INDEX_W'($urandom_range(0, MAX_V - 1));
        it.row_bits     = ROW_BITS_W'($urandom);
        it.start_vertex = INDEX_W'(v);
        return it;
    endfunction

    function automatic logic [ROW_BITS_W-1:0] random_row();
        logic [ROW_BITS_W-1:0] r;
        case ($urandom_range(0, 5))
            0: r = ROW_BITS_W'($urandom & $urandom & $urandom);
            1: r = ROW_BITS_W'($urandom & $urandom);
            2: r = ROW_BITS_W'($urandom);
            3: r = ROW_BITS_W'($urandom | $urandom);
            4: r = 16'h1 << $urandom_range(0, 15);
            default: r = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
        endcase
        return r;
    endfunction

    function automatic item_t random_item();
        int n;
        n = active_vertices();
        if ($urandom_range(0, 9) < 3)
            return load_item($urandom_range(0, MAX_V - 1), random_row());
        if (n > 0 && $urandom_range(0, 9) < 8)
            return start_item($urandom_range(0, n - 1));
        return start_item($urandom_range(0, MAX_V - 1));
    endfunction

    // Block is idle once all results are back and any trailing load has finished.
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        burst_left = 0;
        while (visit_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_VERTEX_COUNT)
            cfg_count = data;
        else
            cfg_mode = data[0];
    endtask

    task automatic write_config(input logic [COUNT_W-1:0] count, input logic mode);
        wait_idle();
        write_reg(CFG_VERTEX_COUNT, count);
        write_reg(CFG_WALK_MODE, {{(CFG_DATA_W-1){1'b0}}, mode});
    endtask

    // Reset defaults (16 vertices, BFS), then DFS on the same graph.
    task automatic test_directed_walks();
        logic [ROW_BITS_W-1:0] bits;
        for (int v = 0; v < MAX_V; v++)
        begin
            if (v == 0)
                bits = 16'hFFFF;
            else if (v == MAX_V - 1)
                bits = 16'h0000;
            else
                bits = (16'h1 << (v + 1)) | (16'h1 << (MAX_V - 1 - v));
            send_item(load_item(v, bits));
        end
        send_item(start_item(0));
        send_item(start_item(MAX_V - 1));
        send_item(start_item(5));
        wait_idle();
        write_reg(CFG_WALK_MODE, {{(CFG_DATA_W-1){1'b0}}, WALK_DFS});
        send_item(start_item(0));
        send_item(start_item(5));
    endtask

    task automatic test_bad_start_and_count_limits();
        wait_idle();
        write_reg(CFG_VERTEX_COUNT, 5'd4);
        send_item(start_item(4));
        send_item(start_item(15));
        send_item(start_item(3));
        write_config(5'd0, WALK_BFS);
        send_item(start_item(0));
        wait_idle();
        write_reg(CFG_VERTEX_COUNT, 5'd1);
        send_item(start_item(0));
        wait_idle();
        write_reg(CFG_VERTEX_COUNT, 5'd31);
        send_item(start_item(15));
    endtask

    // Result side holds off while starts keep coming, so the input backs up.
    task automatic test_output_backpressure();
        write_config(5'd16, WALK_DFS);
        hold_requests++;
        for (int k = 0; k < 12; k++)
            send_item(start_item($urandom_range(0, MAX_V - 1)));
    endtask

    task automatic test_random_graphs();
        logic [COUNT_W-1:0] count;
        logic mode;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: count = 5'd16;
                1: count = 5'd1;
                2: count = 5'd2;
                3: count = 5'd0;
                4: count = 5'd31;
                5: count = 5'd17;
                default: count = ($urandom_range(0, 2) == 0) ? 5'd16 : 5'($urandom_range(1, 31));
            endcase
            mode = (phase < 6) ? phase[0] : 1'($urandom_range(0, 1));
            write_config(count, mode);
            repeat (PHASE_ITEMS) send_item(random_item());
        end
    endtask

    task automatic finish_run();
        item_ch.valid <= 1'b0;
        while (visit_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    endtask

    initial
    begin
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= CFG_VERTEX_COUNT;
        cfg_data             <= '0;
        item_ch.valid        <= 1'b0;
        item_ch.cmd          <= CMD_LOAD_ROW;
        item_ch.row_index    <= '0;
        item_ch.row_bits     <= '0;
        item_ch.start_vertex <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_walks();
        test_bad_start_and_count_limits();
        test_output_backpressure();
        test_random_graphs();
        finish_run();
    end

endmodule
